>>> src/lzss_window_decoder_core_assert.svh
// Assertion macros used by the checker file.
`ifndef LZSS_WINDOW_DECODER_CORE_ASSERT_SVH
`define LZSS_WINDOW_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZSSWD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LZSSWD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lzsswd_pkg.sv
`default_nettype none

package lzsswd_pkg;

  localparam int unsigned WindowBytesDefault = 4096;
  localparam int unsigned QueueDepthDefault  = 2;

  localparam int unsigned LimitW = 24;
  localparam int unsigned DistW  = 13;
  localparam int unsigned LenW   = 5;

  localparam logic [LimitW-1:0] LimitReset = 24'd64000;
  localparam logic [3:0]        FlagPosEmpty = 4'd8;
  localparam logic [LenW-1:0]   LenBias = 5'd2;

  // Index of each flag inside the result tuser word.
  localparam int unsigned UserByteValid = 0;
  localparam int unsigned UserBadDist   = 1;
  localparam int unsigned UserFrameDone = 2;
  localparam int unsigned UserW         = 3;

  typedef enum logic [1:0] {
    OP_LITERAL = 2'd0,
    OP_COPY    = 2'd1,
    OP_MARK    = 2'd2
  } op_kind_e;

  // One unit of work for the back end.
  typedef struct packed {
    op_kind_e          kind;
    logic [7:0]        lit;
    logic [DistW-1:0]  offset;
    logic [LenW-1:0]   len;
    logic              bad;
    logic              frame_end;
  } op_t;

endpackage

`default_nettype wire

>>> src/lzsswd_ram.sv
`default_nettype none

module lzsswd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/lzsswd_front.sv
`default_nettype none

module lzsswd_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_tvalid_i,
  output logic                            s_tready_o,
  input  wire logic [7:0]                 s_tdata_i,
  input  wire logic                       s_tlast_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [lzsswd_pkg::LimitW-1:0] cfg_data_i,
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output lzsswd_pkg::op_t                 q_op_o
);
  import lzsswd_pkg::*;

  logic [LimitW-1:0] limit_q, count_q, count_d;
  logic [7:0]        flag_bits_q, flag_bits_d;
  logic [3:0]        flag_pos_q, flag_pos_d;
  logic [7:0]        pending_q, pending_d;
  logic              await_q, await_d;
  logic              stopped_q, stopped_d;

  logic              accept;
  logic              op_valid;
  logic [LimitW:0]   room_w;
  logic [LimitW-1:0] room;
  logic              stop_now;
  logic [15:0]       cmd;
  logic [DistW-1:0]  offset;
  logic [LenW-1:0]   len_full;
  logic [LenW-1:0]   len_clip;

  assign s_tready_o  = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = s_tvalid_i && !q_full_i;

  // Room left before the limit; a borrow means the limit was lowered below the count.
  assign room_w   = {1'b0, limit_q} - {1'b0, count_q};
  assign room     = room_w[LimitW-1:0];
  assign stop_now = stopped_q || room_w[LimitW] || (room_w == '0);

  assign cmd      = {s_tdata_i, pending_q};
  assign offset   = {1'b0, cmd[15:4]} + DistW'(1);
  assign len_full = {1'b0, cmd[3:0]} + LenBias;
  assign len_clip = (room < LimitW'(len_full)) ? room[LenW-1:0] : len_full;

  always_comb begin
    count_d     = count_q;
    flag_bits_d = flag_bits_q;
    flag_pos_d  = flag_pos_q;
    pending_d   = pending_q;
    await_d     = await_q;
    stopped_d   = stop_now;
    op_valid    = 1'b0;
    q_op_o      = '{kind: OP_MARK, lit: s_tdata_i, offset: offset, len: len_clip,
                    bad: 1'b0, frame_end: s_tlast_i};

    if (!stop_now) begin
      if (flag_pos_q[3]) begin
        flag_bits_d = s_tdata_i;
        flag_pos_d  = '0;
      end else if (await_q) begin
        await_d = 1'b0;
        if (count_q < LimitW'(offset)) begin
          q_op_o.bad = 1'b1;
          op_valid   = 1'b1;
          stopped_d  = 1'b1;
        end else begin
          q_op_o.kind = OP_COPY;
          op_valid    = 1'b1;
          count_d     = count_q + LimitW'(len_clip);
          stopped_d   = (room <= LimitW'(len_full));
          flag_pos_d  = flag_pos_q + 4'd1;
        end
      end else if (flag_bits_q[flag_pos_q[2:0]]) begin
        q_op_o.kind = OP_LITERAL;
        op_valid    = 1'b1;
        count_d     = count_q + LimitW'(1);
        stopped_d   = (room == LimitW'(1));
        flag_pos_d  = flag_pos_q + 4'd1;
      end else begin
        pending_d = s_tdata_i;
        await_d   = 1'b1;
      end
    end

    // A frame end always leaves one result, even when nothing was decoded.
    q_push_o = accept && (op_valid || s_tlast_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      count_q     <= '0;
      flag_bits_q <= '0;
      flag_pos_q  <= FlagPosEmpty;
      pending_q   <= '0;
      await_q     <= 1'b0;
      stopped_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        if (s_tlast_i) begin
          count_q     <= '0;
          flag_bits_q <= '0;
          flag_pos_q  <= FlagPosEmpty;
          pending_q   <= '0;
          await_q     <= 1'b0;
          stopped_q   <= 1'b0;
        end else begin
          count_q     <= count_d;
          flag_bits_q <= flag_bits_d;
          flag_pos_q  <= flag_pos_d;
          pending_q   <= pending_d;
          await_q     <= await_d;
          stopped_q   <= stopped_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lzsswd_queue.sv
`default_nettype none

module lzsswd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lzsswd_pkg::op_t push_op_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output lzsswd_pkg::op_t      head_op_o,
  output logic                 empty_o
);
  import lzsswd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  op_t             entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;

  assign full_o    = (fill_q == CntW'(DEPTH));
  assign empty_o   = (fill_q == '0);
  assign head_op_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lzsswd_back.sv
`default_nettype none

module lzsswd_back #(
  parameter int unsigned WINDOW_BYTES = lzsswd_pkg::WindowBytesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_empty_i,
  input  wire lzsswd_pkg::op_t              q_head_i,
  output logic                              q_pop_o,
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic [7:0]                        m_tdata_o,
  output logic                              m_tlast_o,
  output logic [lzsswd_pkg::UserW-1:0]      m_tuser_o
);
  import lzsswd_pkg::*;

  localparam int unsigned AddrW = $clog2(WINDOW_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e           state_q, state_d;
  op_t              op_q;
  logic [LenW-1:0]  cnt_q;
  logic [AddrW-1:0] src_q, wp_q;

  logic             out_free;
  logic             emit_fire;
  logic             emit_last;
  logic [7:0]       emit_byte;
  logic [7:0]       rd_byte;
  logic [AddrW:0]   wp_ext, dist_ext, src_ext;
  logic             wr_en;

  assign out_free  = !m_tvalid_o || m_tready_i;
  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;
  assign emit_fire = (state_q == ST_EMIT) && out_free;
  assign emit_last = (op_q.kind != OP_COPY) || (cnt_q == LenW'(1));
  assign emit_byte = (op_q.kind == OP_COPY) ? rd_byte :
                     (op_q.kind == OP_LITERAL) ? op_q.lit : 8'd0;
  assign wr_en     = emit_fire && (op_q.kind != OP_MARK);

  // Copy source sits offset bytes behind the write pointer, wrapping around the window.
  assign wp_ext   = {1'b0, wp_q};
  assign dist_ext = (AddrW + 1)'(q_head_i.offset);
  assign src_ext  = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                         : (wp_ext + (AddrW + 1)'(WINDOW_BYTES) - dist_ext);

  lzsswd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (emit_byte),
    .re_i    (state_q == ST_READ),
    .raddr_i (src_q),
    .rdata_o (rd_byte)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_head_i.kind == OP_COPY) ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = emit_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q  <= q_head_i;
      src_q <= src_ext[AddrW-1:0];
    end else if (emit_fire) begin
      src_q <= (src_q == AddrW'(WINDOW_BYTES - 1)) ? '0 : src_q + AddrW'(1);
    end
    if (emit_fire) begin
      m_tdata_o <= emit_byte;
      m_tlast_o <= emit_last;
      m_tuser_o[UserByteValid] <= (op_q.kind != OP_MARK);
      m_tuser_o[UserBadDist]   <= op_q.bad;
      m_tuser_o[UserFrameDone] <= op_q.frame_end && emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      wp_q       <= '0;
      m_tvalid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        cnt_q <= q_head_i.len;
      end else if (emit_fire) begin
        cnt_q <= cnt_q - LenW'(1);
      end
      if (wr_en) begin
        wp_q <= (wp_q == AddrW'(WINDOW_BYTES - 1)) ? '0 : wp_q + AddrW'(1);
      end
      if (emit_fire) begin
        m_tvalid_o <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lzss_window_decoder_core.sv
// Channel   | Direction | Signals                               | Carries
// s_axis    | in        | tvalid tready tdata[7:0] tlast        | compressed byte, frame end
// m_axis    | out       | tvalid tready tdata[7:0] tlast tuser  | decoded byte and flags
// cfg       | in        | cfg_valid_i cfg_ready_o cfg_data_i    | output limit (24 bits)
//
// The front end decodes one input byte per cycle into a two-entry op queue, while the queue
// is not full. The back end takes a literal, empty or error result through its idle and emit
// states, and a copy through a history RAM read then a write for each copied byte.
// Reset clears all control state; the history RAM is never cleared.
// Either side may stall on its own; the output register holds a result until taken.
`default_nettype none

module lzss_window_decoder_core #(
  parameter int unsigned WINDOW_BYTES = lzsswd_pkg::WindowBytesDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [7:0] out_byte
  output logic                               m_axis_tlast,
  // [0] byte_valid, [1] bad_distance, [2] frame_done
  output logic [lzsswd_pkg::UserW-1:0]       m_axis_tuser,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lzsswd_pkg::LimitW-1:0] cfg_data_i
);
  import lzsswd_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  op_t  push_op, head_op;

  lzsswd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (push_op)
  );

  lzsswd_queue #(
    .DEPTH (QueueDepthDefault)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .head_op_o (head_op),
    .empty_o   (q_empty)
  );

  lzsswd_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (head_op),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> src/lzsswd_checker.sv
`default_nettype none

`include "lzss_window_decoder_core_assert.svh"

module lzsswd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [7:0]                  m_axis_tdata,
  input wire logic                        m_axis_tlast,
  input wire logic [lzsswd_pkg::UserW-1:0] m_axis_tuser
);
  import lzsswd_pkg::*;

  // A result without a decoded byte carries a zero byte.
  `LZSSWD_ASSERT_NOW(a_empty_zero, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tuser[UserByteValid], m_axis_tdata == 8'd0,
    "result without byte has nonzero data")
  // The close of a frame is always the last result of its item.
  `LZSSWD_ASSERT_NOW(a_done_last, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser[UserFrameDone], m_axis_tlast,
    "frame_done without tlast")
  // An error result never carries a byte and ends its item.
  `LZSSWD_ASSERT_NOW(a_bad_alone, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser[UserBadDist],
    !m_axis_tuser[UserByteValid] && m_axis_tlast,
    "bad_distance result carries a byte")
  // A stalled result stays in place.
  `LZSSWD_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "stalled result changed")

endmodule

bind lzss_window_decoder_core lzsswd_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/lzss_window_decoder_core_test.sv
module lzss_window_decoder_core_test;
  import lzsswd_pkg::*;

  localparam int unsigned WinBytes    = WindowBytesDefault;
  localparam int unsigned QuietCycles = 64;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned MaxReports  = 40;
  localparam logic [LimitW-1:0] LimitMax = '1;

  typedef struct {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       bad_distance;
    logic       run_last;
    logic       frame_done;
  } decoded_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;           // [7:0] out_byte
  logic              m_axis_tlast;
  logic [UserW-1:0]  m_axis_tuser;           // [0] byte_valid, [1] bad_distance, [2] frame_done
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i = '0;

  // Decoder state as the predictor sees it.
  logic [7:0]        win_mem [WinBytes];
  logic [11:0]       win_wr = '0;
  logic [LimitW-1:0] frame_count = '0;
  logic [LimitW-1:0] limit_reg = LimitReset;
  logic [7:0]        flag_reg = '0;
  logic [3:0]        flag_idx = FlagPosEmpty;
  logic [7:0]        cmd_low = '0;
  bit                cmd_wait = 1'b0;
  bit                frame_halted = 1'b0;

  decoded_t    decoded_q[$];
  decoded_t    head_res;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_toggle = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  lzss_window_decoder_core #(.WINDOW_BYTES(WinBytes)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic store_byte(input logic [7:0] b);
    win_mem[win_wr] = b;
    win_wr = win_wr + 12'd1;
    frame_count = frame_count + 1'b1;
    if (frame_count >= limit_reg) frame_halted = 1'b1;
  endtask

  // Works out the decoded bytes that one compressed byte releases.
  task automatic decode_step(input logic [7:0] d, input logic last);
    decoded_t    res[$];
    logic [15:0] cmd;
    logic [7:0]  b;
    int unsigned offset, len, room, i;
    bit          bad;
    bad = 1'b0;
    if (frame_count >= limit_reg) frame_halted = 1'b1;
    if (!frame_halted) begin
      if (flag_idx >= FlagPosEmpty) begin
        flag_reg = d;
        flag_idx = '0;
      end else if (cmd_wait) begin
        cmd = {d, cmd_low};
        offset = cmd[15:4] + 1;
        cmd_wait = 1'b0;
        if (frame_count < offset) begin
          bad = 1'b1;
          frame_halted = 1'b1;
        end else begin
          len = cmd[3:0] + 2;
          room = limit_reg - frame_count;
          if (len > room) len = room;
          // Byte by byte, so a short distance repeats what was just written.
          for (i = 0; i < len; i++) begin
            b = win_mem[win_wr - 12'(offset)];
            res.push_back('{b, 1'b1, 1'b0, 1'b0, 1'b0});
            store_byte(b);
          end
          flag_idx = flag_idx + 4'd1;
        end
      end else if (flag_reg[flag_idx[2:0]]) begin
        res.push_back('{d, 1'b1, 1'b0, 1'b0, 1'b0});
        store_byte(d);
        flag_idx = flag_idx + 4'd1;
      end else begin
        cmd_low = d;
        cmd_wait = 1'b1;
      end
    end
    if (res.size() == 0 && (bad || last)) res.push_back('{8'h00, 1'b0, bad, 1'b0, 1'b0});
    if (res.size() != 0) begin
      res[res.size()-1].run_last = 1'b1;
      res[res.size()-1].frame_done = last;
    end
    for (i = 0; i < res.size(); i++) decoded_q.push_back(res[i]);
    if (last) begin
      frame_count = '0;
      flag_reg = '0;
      flag_idx = FlagPosEmpty;
      cmd_low = '0;
      cmd_wait = 1'b0;
      frame_halted = 1'b0;
    end
  endtask

  // Leaves tvalid high; the caller lowers it through drain_decoder.
  task automatic send_byte(input logic [7:0] d, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_step(d, last);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    int i;
    for (i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic drain_decoder();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
    // Flag bytes and command low bytes release nothing, so let them settle too.
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [LimitW-1:0] v);
    drain_decoder();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_reg = v;
  endtask

  // A frame of random literals and copies, where a copy may reach too far back; optionally
  // one trailing byte, which may be a flag, a literal or a command low byte cut off by the end.
  task automatic send_coded_frame(input int unsigned n_tokens, input int unsigned bad_pct,
                                  input int unsigned copy_pct);
    logic [7:0]  q[$];
    logic [7:0]  flag;
    logic [15:0] cmd;
    int unsigned made, tok, reach, offset, len, b;
    made = 0;
    tok = 0;
    do begin
      for (b = 0; b < 8; b++) flag[b] = ($urandom_range(99) >= copy_pct);
      q.push_back(flag);
      for (b = 0; b < 8 && tok < n_tokens; b++) begin
        tok++;
        if (flag[b]) begin
          q.push_back(8'($urandom));
          made++;
        end else begin
          reach = (made < WinBytes) ? made : WinBytes;
          if (reach < WinBytes && (reach == 0 || $urandom_range(99) < bad_pct))
            offset = $urandom_range(WinBytes, reach + 1);
          else if ($urandom_range(3) == 0)
            offset = $urandom_range(reach, 1);
          else
            offset = $urandom_range((reach < 8) ? reach : 8, 1);
          len = $urandom_range(17, 2);
          cmd = {12'(offset - 1), 4'(len - 2)};
          q.push_back(cmd[7:0]);
          q.push_back(cmd[15:8]);
          made += len;
        end
      end
    end while (tok < n_tokens);
    if ($urandom_range(1) == 1) q.push_back(8'($urandom));
    send_bytes(q);
  endtask

  task automatic send_random_frame();
    logic [7:0]  q[$];
    int unsigned n, i;
    if ($urandom_range(99) < 20) begin
      n = $urandom_range(10, 1);
      for (i = 0; i < n; i++) q.push_back(8'($urandom));
      send_bytes(q);
    end else begin
      send_coded_frame($urandom_range(14, 0), 8, 40);
    end
  endtask

  task automatic test_literals_and_copies();
    // Three literals, an overlapping copy of the longest length, a short copy.
    send_byte(8'h07, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_bad_distance();
    // The copy reaches 4096 bytes back with one byte written, so the frame stops.
    send_byte(8'h01, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
  endtask

  task automatic test_cut_off_command();
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b1);
  endtask

  task automatic test_output_limit();
    set_limit(24'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b1);
    // A five-byte copy is cut to two.
    set_limit(24'd3);
    send_byte(8'h01, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h00, 1'b1);
    set_limit(24'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h99, 1'b1);
  endtask

  task automatic test_limit_change_mid_frame();
    set_limit(LimitMax);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    set_limit(24'd2);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_items);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_limit(LimitW'($urandom_range(48, 8)));
    stop_at = items_sent + n_items / 2;
    while (items_sent < stop_at) send_random_frame();
    set_limit(LimitW'($urandom_range(LimitMax, 4096)));
    stop_at = items_sent + n_items / 2;
    while (items_sent < stop_at) send_random_frame();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limit(LimitReset);
    // The receiver stops for a long stretch while the sender keeps offering.
    hold_toggle = ~hold_toggle;
    send_coded_frame(12, 0, 60);
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result transfer is matched against the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: result with nothing pending, expected none, got byte %0h tuser %0b",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        head_res = decoded_q.pop_front();
        check_field("out_byte", head_res.out_byte, m_axis_tdata);
        check_field("byte_valid", head_res.byte_valid, m_axis_tuser[UserByteValid]);
        check_field("bad_distance", head_res.bad_distance, m_axis_tuser[UserBadDist]);
        check_field("run_last", head_res.run_last, m_axis_tlast);
        check_field("frame_done", head_res.frame_done, m_axis_tuser[UserFrameDone]);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 9;
    recv_idle_pct = 61;
    test_literals_and_copies();
    test_bad_distance();
    test_cut_off_command();
    test_output_limit();
    test_limit_change_mid_frame();
    test_random_traffic(9, 61, 24);
    test_random_traffic(61, 9, 24);
    test_backpressure();
    test_random_traffic(0, 0, 24);
    drain_decoder();
    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/lzsswd_pkg.sv
src/lzsswd_ram.sv
src/lzsswd_front.sv
src/lzsswd_queue.sv
src/lzsswd_back.sv
src/lzss_window_decoder_core.sv
src/lzsswd_checker.sv
tb/lzss_window_decoder_core_test.sv
